@@ rtl/core/sliding_median_delay_filter_top_assert.svh @@
// ----------------------------------------------------------------------------
// Sliding median delay filter assertion macros
// Concurrent checks on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef SLIDING_MEDIAN_DELAY_FILTER_TOP_ASSERT_SVH
`define SLIDING_MEDIAN_DELAY_FILTER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define SMDF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("smdf same-cycle check failed");
`define SMDF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("smdf next-cycle check failed");
`else
`define SMDF_ASSERT_NOW(lbl, ante, cons)
`define SMDF_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ rtl/core/smdf_pkg.sv @@
// ----------------------------------------------------------------------------
// Sliding median delay filter package
// Window size, field widths, command codes and cell link types.
// ----------------------------------------------------------------------------
`default_nettype none

package smdf_pkg;

  localparam int WINDOW = 8;
  localparam int DATA_W = 32;
  localparam int USED_W = 4;
  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W  = $clog2(WINDOW + 1);

  localparam logic CMD_PUSH  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  typedef logic signed [DATA_W-1:0] sample_t;
  typedef logic [SLOT_W-1:0]        slot_t;
  typedef logic [CNT_W-1:0]         cnt_t;

  typedef struct packed {
    logic    push;
    logic    clear;
    sample_t sample;
    slot_t   slot;
    logic    evict_en;
  } cell_ctrl_t;

  typedef struct packed {
    sample_t value;
    slot_t   tag;
    logic    valid;
    logic    le;
    logic    k;
  } cell_link_t;

endpackage

`default_nettype wire

@@ rtl/core/smdf_cell.sv @@
// ----------------------------------------------------------------------------
// Sorted window cell
// Holds one sample and its slot tag; evicts, keeps, inserts or shifts.
// ----------------------------------------------------------------------------
`default_nettype none

module smdf_cell import smdf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  cell_link_t prev_link,
  input  cell_link_t next_link,
  output cell_link_t link
);

  sample_t value;
  slot_t   tag;
  logic    valid;

  logic    evict;
  logic    le;
  logic    k;
  logic    keep;
  logic    take_new;
  sample_t cur_value;
  slot_t   cur_tag;
  sample_t prv_value;
  slot_t   prv_tag;

  always_comb begin
    evict     = ctrl.evict_en && valid && (tag == ctrl.slot);
    le        = valid && ($signed(value) <= $signed(ctrl.sample));
    k         = prev_link.k || evict;
    keep      = k ? next_link.le : le;
    take_new  = prev_link.k ? le : prev_link.le;
    cur_value = k ? next_link.value : value;
    cur_tag   = k ? next_link.tag : tag;
    prv_value = prev_link.k ? value : prev_link.value;
    prv_tag   = prev_link.k ? tag : prev_link.tag;
    link.value = value;
    link.tag   = tag;
    link.valid = valid;
    link.le    = le;
    link.k     = k;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.clear) begin
      valid <= 1'b0;
    end else if (ctrl.push) begin
      valid <= valid || (!ctrl.evict_en && prev_link.valid);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      if (keep) begin
        value <= cur_value;
        tag   <= cur_tag;
      end else if (take_new) begin
        value <= ctrl.sample;
        tag   <= ctrl.slot;
      end else begin
        value <= prv_value;
        tag   <= prv_tag;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/smdf_chain.sv @@
// ----------------------------------------------------------------------------
// Sorted cell chain
// Row of WINDOW cells kept in ascending order, smallest in cell zero.
// ----------------------------------------------------------------------------
`default_nettype none

module smdf_chain import smdf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cell_ctrl_t        ctrl,
  output sample_t           values [WINDOW],
  output logic [WINDOW-1:0] valids
);

  cell_link_t links [WINDOW];
  cell_link_t low_edge;
  cell_link_t high_edge;

  always_comb begin
    low_edge.value  = '0;
    low_edge.tag    = '0;
    low_edge.valid  = 1'b1;
    low_edge.le     = 1'b1;
    low_edge.k      = 1'b0;
    high_edge.value = '0;
    high_edge.tag   = '0;
    high_edge.valid = 1'b0;
    high_edge.le    = 1'b0;
    high_edge.k     = 1'b0;
  end

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    cell_link_t prev_l;
    cell_link_t next_l;

    if (i == 0) begin : g_lo
      assign prev_l = low_edge;
    end else begin : g_mid_lo
      assign prev_l = links[i-1];
    end

    if (i == WINDOW - 1) begin : g_hi
      assign next_l = high_edge;
    end else begin : g_mid_hi
      assign next_l = links[i+1];
    end

    smdf_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .prev_link (prev_l),
      .next_link (next_l),
      .link      (links[i])
    );

    assign values[i] = links[i].value;
    assign valids[i] = links[i].valid;
  end

endmodule

`default_nettype wire

@@ rtl/core/smdf_median.sv @@
// ----------------------------------------------------------------------------
// Median output stage
// Picks the middle cells, averages toward zero and holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module smdf_median import smdf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  cnt_t              cnt,
  input  sample_t           values [WINDOW],
  input  logic              out_ready,
  output logic              out_valid,
  output logic [DATA_W-1:0] median_ns,
  output logic [USED_W-1:0] samples_used
);

  cnt_t                    lo_cnt;
  cnt_t                    hi_cnt;
  slot_t                   lo_idx;
  slot_t                   hi_idx;
  logic signed [DATA_W:0]  sum;
  logic signed [DATA_W:0]  adj;
  logic [USED_W+CNT_W-1:0] used_wide;

  always_comb begin
    lo_cnt    = (cnt - cnt_t'(1)) >> 1;
    hi_cnt    = cnt >> 1;
    lo_idx    = lo_cnt[SLOT_W-1:0];
    hi_idx    = hi_cnt[SLOT_W-1:0];
    sum       = {values[lo_idx][DATA_W-1], values[lo_idx]}
              + {values[hi_idx][DATA_W-1], values[hi_idx]};
    adj       = sum + {{DATA_W{1'b0}}, sum[DATA_W] & sum[0]};
    used_wide = {{USED_W{1'b0}}, cnt};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      median_ns    <= adj[DATA_W:1];
      samples_used <= used_wide[USED_W-1:0];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/sliding_median_delay_filter_top.sv @@
// ----------------------------------------------------------------------------
// Sliding median delay filter
// Median of the newest WINDOW delay samples, kept sorted in a cell chain.
// ----------------------------------------------------------------------------
//  channel | signals                             | role
//  in      | in_valid, in_ready, cmd, delay_ns   | push a sample or clear window
//  out     | out_valid, out_ready, median_ns,    | one median per push
//          | samples_used                        |
//
//  One transaction a cycle while in_ready is high: the chain evicts and
//  inserts in the accept cycle, the median stage reads the chain in the
//  following cycle unless the output stalls, and registers the median.
//  A stalled output blocks in_ready once a second median waits in the chain.
//  Reset empties the window; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sliding_median_delay_filter_top_assert.svh"

module sliding_median_delay_filter_top import smdf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              cmd,
  input  logic [DATA_W-1:0] delay_ns,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] median_ns,
  output logic [USED_W-1:0] samples_used
);

  slot_t             write_slot;
  slot_t             write_slot_next;
  logic              window_filled;
  logic              window_filled_next;
  logic              pend;
  logic              pend_next;
  cnt_t              pend_cnt;
  cnt_t              push_cnt;

  logic              accept;
  logic              push;
  logic              clear;
  logic              move;
  logic              load;
  logic              last_slot;
  cell_ctrl_t        ctrl;
  sample_t           values [WINDOW];
  logic [WINDOW-1:0] valids;

  always_comb begin
    move      = !out_valid || out_ready;
    load      = pend && move;
    in_ready  = !pend || move;
    accept    = in_valid && in_ready;
    push      = accept && (cmd == CMD_PUSH);
    clear     = accept && (cmd == CMD_CLEAR);
    last_slot = (write_slot == slot_t'(WINDOW - 1));

    write_slot_next    = write_slot;
    window_filled_next = window_filled;
    if (clear) begin
      write_slot_next    = '0;
      window_filled_next = 1'b0;
    end else if (push) begin
      if (last_slot) begin
        write_slot_next    = '0;
        window_filled_next = 1'b1;
      end else begin
        write_slot_next = write_slot + slot_t'(1);
      end
    end

    if (window_filled || last_slot) begin
      push_cnt = cnt_t'(WINDOW);
    end else begin
      push_cnt = cnt_t'(write_slot) + cnt_t'(1);
    end

    if (push) begin
      pend_next = 1'b1;
    end else if (load) begin
      pend_next = 1'b0;
    end else begin
      pend_next = pend;
    end

    ctrl.push     = push;
    ctrl.clear    = clear;
    ctrl.sample   = delay_ns;
    ctrl.slot     = write_slot;
    ctrl.evict_en = window_filled;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot    <= '0;
      window_filled <= 1'b0;
      pend          <= 1'b0;
    end else begin
      write_slot    <= write_slot_next;
      window_filled <= window_filled_next;
      pend          <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      pend_cnt <= push_cnt;
    end
  end

  smdf_chain u_chain (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .values (values),
    .valids (valids)
  );

  smdf_median u_median (
    .clk          (clk),
    .rst          (rst),
    .load         (load),
    .cnt          (pend_cnt),
    .values       (values),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .median_ns    (median_ns),
    .samples_used (samples_used)
  );

  `SMDF_ASSERT_NOW(a_stall_blocks_input, pend && !move, !in_ready)
  `SMDF_ASSERT_NEXT(a_push_pends, push, pend)
  `SMDF_ASSERT_NOW(a_filled_all_valid, window_filled, &valids)
  `SMDF_ASSERT_NEXT(a_clear_empties, clear, (valids == '0) && !window_filled)

endmodule

`default_nettype wire

@@ test/tb_sliding_median_delay_filter_top.sv @@
// ----------------------------------------------------------------------------
// Sliding median delay filter testbench
// Drives push and clear transactions with random gaps and output stalls,
// predicts each median from a private window copy and checks every result
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sliding_median_delay_filter_top;
  import smdf_pkg::*;

  localparam int IDLE_LIMIT = 1000;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    sample_t           median;
    logic [USED_W-1:0] used;
  } median_rec_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              cmd = CMD_PUSH;
  logic [DATA_W-1:0] delay_ns = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [DATA_W-1:0] median_ns;
  logic [USED_W-1:0] samples_used;

  sample_t     win_samples [WINDOW];
  int          win_slot = 0;
  bit          win_full = 1'b0;
  median_rec_t pending_medians [$];

  int mismatch_count = 0;
  int idle_cycles = 0;
  int hold_cycles = 0;
  bit send_idle_en = 1'b1;
  bit recv_idle_en = 1'b1;

  sliding_median_delay_filter_top uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .delay_ns     (delay_ns),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .median_ns    (median_ns),
    .samples_used (samples_used)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end else begin
      return $urandom_range(8, 40);
    end
  endfunction

  function automatic sample_t random_delay();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      case ($urandom_range(0, 3))
        0: return sample_t'(32'h7FFF_FFFF);
        1: return sample_t'(32'h8000_0000);
        2: return sample_t'(0);
        default: return sample_t'(-1);
      endcase
    end else if (r < 4) begin
      return sample_t'($urandom_range(0, 200) - 100);
    end else begin
      return sample_t'($urandom);
    end
  endfunction

  function automatic void predict_median(input logic c, input sample_t d);
    sample_t     sorted [WINDOW];
    sample_t     key;
    int          count;
    int          j;
    longint      mid_sum;
    median_rec_t rec;
    if (c == CMD_CLEAR) begin
      win_slot = 0;
      win_full = 1'b0;
      return;
    end
    win_samples[win_slot] = d;
    win_slot++;
    if (win_slot >= WINDOW) begin
      win_slot = 0;
      win_full = 1'b1;
    end
    count = win_full ? WINDOW : win_slot;
    for (int i = 0; i < count; i++) sorted[i] = win_samples[i];
    for (int i = 1; i < count; i++) begin
      key = sorted[i];
      j = i;
      while (j > 0 && sorted[j-1] > key) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = key;
    end
    if (count % 2 == 0) begin
      mid_sum = longint'(sorted[count/2 - 1]) + longint'(sorted[count/2]);
      rec.median = sample_t'(mid_sum / 2);
    end else begin
      rec.median = sorted[count/2];
    end
    rec.used = USED_W'(count);
    pending_medians.insert(pending_medians.size(), rec);
  endfunction

  task automatic send_item(input logic c, input sample_t d);
    int gap;
    gap = send_idle_en ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    delay_ns <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_median(c, d);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_medians.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_item(CMD_CLEAR, sample_t'(32'hDEAD_BEEF));
    send_item(CMD_PUSH, sample_t'(32'h7FFF_FFFF));
    send_item(CMD_PUSH, sample_t'(32'h7FFF_FFFF));
    send_item(CMD_PUSH, sample_t'(32'h8000_0000));
    send_item(CMD_PUSH, sample_t'(32'h8000_0000));
    send_item(CMD_CLEAR, sample_t'(32'hFFFF_FFFF));
    send_item(CMD_PUSH, sample_t'(-1));
    send_item(CMD_PUSH, sample_t'(-2));
    send_item(CMD_CLEAR, sample_t'(0));
    send_item(CMD_PUSH, sample_t'(1));
    send_item(CMD_PUSH, sample_t'(2));
    send_item(CMD_PUSH, sample_t'(3));
    send_item(CMD_PUSH, sample_t'(-4));
    send_item(CMD_PUSH, sample_t'(5));
    send_item(CMD_PUSH, sample_t'(-6));
    send_item(CMD_PUSH, sample_t'(7));
    send_item(CMD_PUSH, sample_t'(-8));
    send_item(CMD_PUSH, sample_t'(32'h8000_0000));
    send_item(CMD_PUSH, sample_t'(32'h7FFF_FFFF));
    send_item(CMD_PUSH, sample_t'(0));
    send_item(CMD_CLEAR, sample_t'(32'h5555_5555));
    send_item(CMD_PUSH, sample_t'(32'h5555_5555));
    send_item(CMD_PUSH, sample_t'(32'hAAAA_AAAA));
    wait_drained();
  endtask

  task automatic test_backpressure();
    hold_cycles = 300;
    for (int i = 0; i < 40; i++) send_item(CMD_PUSH, random_delay());
    wait_drained();
  endtask

  task automatic test_random_stream();
    for (int i = 0; i < 500; i++) begin
      if ($urandom_range(0, 99) < 6) begin
        send_item(CMD_CLEAR, sample_t'($urandom));
      end else begin
        send_item(CMD_PUSH, random_delay());
      end
      if (i == 250) wait_drained();
    end
    wait_drained();
  endtask

  task automatic test_clear_runs();
    int sent;
    int run_len;
    sent = 0;
    send_idle_en = 1'b0;
    recv_idle_en = 1'b0;
    while (sent < 150) begin
      if (sent >= 60) begin
        send_idle_en = 1'b1;
        recv_idle_en = 1'b1;
      end
      run_len = $urandom_range(1, 12);
      for (int i = 0; i < run_len; i++) send_item(CMD_PUSH, random_delay());
      send_item(CMD_CLEAR, sample_t'($urandom));
      sent += run_len + 1;
    end
    wait_drained();
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        hold_cycles--;
      end else if (!recv_idle_en) begin
        out_ready <= 1'b1;
      end else if (pick_gap() > 0 && $urandom_range(0, 1) == 0) begin
        out_ready <= 1'b0;
        repeat (pick_gap()) begin
          @(posedge clk);
          if (hold_cycles > 0) hold_cycles--;
        end
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    median_rec_t rec;
    if (!rst && out_valid && out_ready) begin
      if (pending_medians.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("unexpected result: median_ns=%0d samples_used=%0d",
                   $signed(median_ns), samples_used);
        end
      end else begin
        rec = pending_medians.pop_front();
        if (median_ns !== rec.median || samples_used !== rec.used) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("mismatch: median_ns exp %0d got %0d, samples_used exp %0d got %0d",
                     rec.median, $signed(median_ns), rec.used, samples_used);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random_stream();
    test_clear_runs();
    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && pending_medians.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ sliding_median_delay_filter_top.f @@
+incdir+rtl/core
rtl/core/smdf_pkg.sv
rtl/core/smdf_cell.sv
rtl/core/smdf_chain.sv
rtl/core/smdf_median.sv
rtl/core/sliding_median_delay_filter_top.sv
test/tb_sliding_median_delay_filter_top.sv
